### rtl/kfs_pkg.sv
// Shared types and constants for the PS/2 keyboard frame sender.
package kfs_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [2:0] {
    REQ_MAKE  = 3'd0,
    REQ_BREAK = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_READ  = 3'd3,
    REQ_TICK  = 3'd4
  } req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_KB_EN   = 2'd0,
    CFG_IRQ_EN  = 2'd1,
    CFG_HALF    = 2'd2
  } cfg_idx_t;

  // Frame sender modes
  typedef enum logic [1:0] {
    SND_IDLE    = 2'd0,
    SND_SEND    = 2'd1,
    SND_RECOVER = 2'd2
  } snd_mode_t;

  // Request sequencer states
  typedef enum logic [1:0] {
    ENG_IDLE = 2'd0,
    ENG_KEY  = 2'd1,
    ENG_TICK = 2'd2
  } eng_state_t;

  localparam logic [7:0] BREAK_CODE = 8'hF0;
  localparam logic [7:0] HALF_RESET = 8'd20;
  localparam logic [3:0] FRAME_BITS = 4'd11;
  localparam logic [1:0] LINES_RELEASED = 2'b11;

  // Strobes from the sequencer to the frame sender
  typedef struct packed {
    logic       tick;
    logic       host_wr;
    logic       nonempty;
    logic [1:0] host_lines;
  } snd_ctl_t;

  // Status from the frame sender, valid in the cycle of a strobe
  typedef struct packed {
    logic       pop;
    logic       irq;
    logic [1:0] bus_lines;
  } snd_stat_t;

endpackage

### rtl/kfs_ring_mem.sv
// Byte ring storage: one write port, one registered read port.
module kfs_ring_mem #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [IW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write the pushed byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the head byte
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/kfs_frame_sender.sv
// PS/2 device-to-host frame sender: line state, bit timing and recovery.
module kfs_frame_sender import kfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  snd_ctl_t  ctl,
  input  logic [7:0] head_byte,
  input  logic      irq_en,
  input  logic [7:0] half,
  output snd_stat_t stat
);

  snd_mode_t  mode, mode_next;
  logic [7:0] countdown, countdown_next;
  logic [3:0] bit_pos, bit_pos_next;
  logic [7:0] shift, shift_next;
  logic       parity, parity_next;
  logic [1:0] dev_lines, dev_lines_next;
  logic [1:0] host_latch, host_latch_next;
  logic       pop, irq;

  // Work out one tick or one host write in program order
  always_comb begin
    mode_next       = mode;
    countdown_next  = countdown;
    bit_pos_next    = bit_pos;
    shift_next      = shift;
    parity_next     = parity;
    dev_lines_next  = dev_lines;
    host_latch_next = host_latch;
    pop             = 1'b0;
    irq             = 1'b0;

    if (ctl.tick) begin
      // Start a frame from the ring head
      if (mode_next == SND_IDLE && host_latch[1] && ctl.nonempty) begin
        pop            = 1'b1;
        shift_next     = head_byte;
        mode_next      = SND_SEND;
        countdown_next = half;
        bit_pos_next   = 4'd0;
        dev_lines_next = 2'b10;
        parity_next    = 1'b1;
      end

      // Time the half periods and shift out bits on rising clock
      if (mode_next == SND_SEND) begin
        if (countdown_next != 8'd0) begin
          countdown_next = countdown_next - 8'd1;
        end else begin
          dev_lines_next[1] = ~dev_lines_next[1];
          if (irq_en && !dev_lines_next[1]) begin
            irq = 1'b1;
          end
          countdown_next = half;
          if (bit_pos_next >= FRAME_BITS) begin
            dev_lines_next[1] = 1'b1;
          end
          if (dev_lines_next[1]) begin
            dev_lines_next[0] = 1'b0;
            if (bit_pos_next < 4'd8) begin
              parity_next       = parity_next ^ shift_next[0];
              dev_lines_next[0] = shift_next[0];
              shift_next        = {1'b0, shift_next[7:1]};
            end else if (bit_pos_next == 4'd8) begin
              dev_lines_next[0] = parity_next;
            end else if (bit_pos_next == 4'd9) begin
              dev_lines_next[0] = 1'b1;
            end else if (bit_pos_next == 4'd10) begin
              mode_next      = SND_RECOVER;
              countdown_next = half;
              dev_lines_next = LINES_RELEASED;
            end
            bit_pos_next = bit_pos_next + 4'd1;
          end
        end
      end

      // Hold off the next frame for the recovery time
      if (mode_next == SND_RECOVER) begin
        if (countdown_next == 8'd0) begin
          mode_next = SND_IDLE;
        end else begin
          countdown_next = countdown_next - 8'd1;
        end
      end
    end else if (ctl.host_wr) begin
      // Host pulling clock low aborts the frame
      host_latch_next = ctl.host_lines;
      if (!ctl.host_lines[1]) begin
        mode_next      = SND_IDLE;
        dev_lines_next = LINES_RELEASED;
      end
    end
  end

  assign stat.pop       = pop;
  assign stat.irq       = irq;
  assign stat.bus_lines = host_latch_next & dev_lines_next;

  // Update sender state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= SND_IDLE;
      countdown  <= 8'd0;
      bit_pos    <= 4'd0;
      shift      <= 8'd0;
      parity     <= 1'b1;
      dev_lines  <= LINES_RELEASED;
      host_latch <= LINES_RELEASED;
    end else begin
      mode       <= mode_next;
      countdown  <= countdown_next;
      bit_pos    <= bit_pos_next;
      shift      <= shift_next;
      parity     <= parity_next;
      dev_lines  <= dev_lines_next;
      host_latch <= host_latch_next;
    end
  end

endmodule

### rtl/ps2_keyboard_frame_sender_core.sv
// PS/2 keyboard frame sender top: request buffer, ring sequencer and result register.
// A key event takes one ring write per byte slot (prefix, break mark, code); a tick
// waits for the registered ring read; other requests complete straight from idle.
// Throughput: other requests one per cycle while the output register is free.
// Results wait in an output register.
// Reset (rst, synchronous): indexes, sender state and control registers return to defaults;
// ring contents are not cleared and need no clearing pass.
module ps2_keyboard_frame_sender_core import kfs_pkg::*; #(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] prefix_byte, [15:8] code_byte, [17:16] host_lines
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] bus_lines, [2] clock_flag, [3] interrupt_pulse,
                                 // [5:4] bytes_dropped
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  // Configuration
  logic       kb_en, irq_en;
  logic [7:0] half;

  // Request register
  logic        buf_valid;
  logic [2:0]  buf_req;
  logic [7:0]  buf_prefix, buf_code;
  logic [1:0]  buf_lines;
  logic        buf_take;

  // Sequencer
  eng_state_t state, state_next;
  logic       key_step, key_step_next;
  logic       w_break;
  logic [7:0] w_code;
  logic [1:0] w_drops;

  // Ring
  logic [IW-1:0] rd_idx, wr_idx, wr_idx_inc;
  logic [7:0]    head_byte;
  logic          push, push_full, mem_we;
  logic [7:0]    push_byte;
  logic          done;
  logic          out_free;
  logic [1:0]    drops_total;

  snd_ctl_t  snd_ctl;
  snd_stat_t snd_stat;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = !buf_valid || buf_take;
  assign wr_idx_inc = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
  assign push_full  = (wr_idx_inc == rd_idx);
  assign mem_we     = push && !push_full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kb_en  <= 1'b0;
      irq_en <= 1'b0;
      half   <= HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KB_EN:  kb_en  <= cfg_data[0];
        CFG_IRQ_EN: irq_en <= cfg_data[0];
        CFG_HALF:   half   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Hold one request ahead of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      buf_valid <= 1'b1;
    end else if (buf_take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      buf_req    <= s_tuser;
      buf_prefix <= s_tdata[7:0];
      buf_code   <= s_tdata[15:8];
      buf_lines  <= s_tdata[17:16];
    end
  end

  // Next sequencer state
  always_comb begin
    state_next    = state;
    key_step_next = key_step;
    case (state)
      ENG_IDLE: begin
        if (buf_valid) begin
          if ((buf_req == REQ_MAKE || buf_req == REQ_BREAK) && kb_en) begin
            state_next    = ENG_KEY;
            key_step_next = 1'b0;
          end else if (buf_req == REQ_TICK) begin
            state_next = ENG_TICK;
          end
        end
      end
      ENG_KEY: begin
        if (!key_step) begin
          key_step_next = 1'b1;
        end else if (out_free) begin
          state_next = ENG_IDLE;
        end
      end
      ENG_TICK: begin
        if (out_free) begin
          state_next = ENG_IDLE;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  // Sequencer outputs: ring pushes, sender strobes, completion
  always_comb begin
    buf_take         = 1'b0;
    push             = 1'b0;
    push_byte        = w_code;
    done             = 1'b0;
    snd_ctl.tick     = 1'b0;
    snd_ctl.host_wr  = 1'b0;
    snd_ctl.nonempty = (rd_idx != wr_idx);
    snd_ctl.host_lines = buf_lines;
    drops_total      = w_drops;
    case (state)
      ENG_IDLE: begin
        if (buf_valid) begin
          if ((buf_req == REQ_MAKE || buf_req == REQ_BREAK) && kb_en) begin
            // Push the prefix slot
            buf_take  = 1'b1;
            push      = (buf_prefix != 8'd0);
            push_byte = buf_prefix;
          end else if (buf_req == REQ_TICK) begin
            // Ring head read is in flight
            buf_take = 1'b1;
          end else if (out_free) begin
            buf_take        = 1'b1;
            done            = 1'b1;
            snd_ctl.host_wr = (buf_req == REQ_WRITE);
            drops_total     = 2'd0;
          end
        end
      end
      ENG_KEY: begin
        if (!key_step) begin
          // Push the break mark slot
          push      = w_break;
          push_byte = BREAK_CODE;
        end else if (out_free) begin
          // Push the code and finish
          push        = 1'b1;
          push_byte   = w_code;
          done        = 1'b1;
          drops_total = w_drops + {1'b0, push_full};
        end
      end
      ENG_TICK: begin
        if (out_free) begin
          snd_ctl.tick = 1'b1;
          done         = 1'b1;
          drops_total  = 2'd0;
        end
      end
      default: ;
    endcase
  end

  // Advance sequencer and key event work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ENG_IDLE;
      key_step <= 1'b0;
      w_drops  <= 2'd0;
    end else begin
      state    <= state_next;
      key_step <= key_step_next;
      if (state == ENG_IDLE) begin
        w_drops <= {1'b0, push && push_full};
      end else if (push && push_full) begin
        w_drops <= w_drops + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ENG_IDLE && buf_valid) begin
      w_break <= (buf_req == REQ_BREAK);
      w_code  <= buf_code;
    end
  end

  // Advance ring indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
    end else begin
      if (mem_we) begin
        wr_idx <= wr_idx_inc;
      end
      if (snd_stat.pop) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end
    end
  end

  kfs_ring_mem #(
    .DEPTH (RING_DEPTH),
    .IW    (IW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx),
    .wdata (push_byte),
    .raddr (rd_idx),
    .rdata (head_byte)
  );

  kfs_frame_sender u_sender (
    .clk       (clk),
    .rst       (rst),
    .ctl       (snd_ctl),
    .head_byte (head_byte),
    .irq_en    (irq_en),
    .half      (half),
    .stat      (snd_stat)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {2'b00, drops_total, snd_stat.irq, snd_stat.bus_lines[1],
                  snd_stat.bus_lines};
    end
  end

endmodule
